// File: hdl/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared widths, key codes, limits and interface structs for the servo pan
// sweep controller and its shared divide unit.
// ----------------------------------------------------------------------------
package spsc_pkg;

  // stream payload widths
  localparam int KEY_W      = 8;
  localparam int NOW_W      = 32;
  localparam int S_DATA_W   = 40;
  localparam int ANGLE_W    = 8;
  localparam int LED_W      = 11;
  localparam int M_DATA_W   = 24;
  localparam int OUT_PAD_W  = M_DATA_W - ANGLE_W - LED_W;

  // stored tick width, equal to the now_ms width, so all bits of now_ms take part
  localparam int TICK_W     = 32;

  // sweep period and divide unit widths
  localparam int PERIOD_W   = 15;
  localparam int DIVIDEND_W = 21;
  localparam int QUOT_W     = 7;
  localparam int POS_W      = 4;

  // key codes
  localparam logic [KEY_W-1:0] KEY_NEXT  = 8'h6E;
  localparam logic [KEY_W-1:0] KEY_PREV  = 8'h70;
  localparam logic [KEY_W-1:0] KEY_METRO = 8'h6D;
  localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
  localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;

  // manual stepping
  localparam logic signed [ANGLE_W-1:0] ANGLE_STEP = 8'sd10;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX  = 8'sd70;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN  = -8'sd70;

  // sweep period limits
  localparam logic [PERIOD_W-1:0] PERIOD_STEP  = 15'd1000;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 15'd2000;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 15'd20000;
  localparam logic [PERIOD_W-1:0] PERIOD_LOWER = 15'd3000;

  // sweep amplitude and led scaling
  localparam logic signed [ANGLE_W-1:0] SWEEP_HALF = 8'sd40;
  localparam logic [PERIOD_W-1:0]       LED_MAN_DIV = 15'd14;
  localparam int                        LED_MET_SHIFT = 3;
  localparam logic [POS_W-1:0]          POS_LAST = 4'd10;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PERIOD_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hdl/spsc_divider.sv
// ----------------------------------------------------------------------------
// spsc_divider
// Restoring divider, one compare and subtract per cycle, producing a quotient
// that is known to fit QUOT_W bits.
// ----------------------------------------------------------------------------
module spsc_divider (
  input  logic                clk,
  input  logic                rst,
  input  spsc_pkg::div_req_t  req,
  output spsc_pkg::div_rsp_t  rsp
);
  import spsc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] dsh;
  logic [QUOT_W-1:0]     quot;
  logic                  ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W - 1);
        rem  <= req.dividend;
        // divisor aligned to the top quotient bit
        dsh  <= DIVIDEND_W'(req.divisor) << (QUOT_W - 1);
        quot <= '0;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - dsh;
        end
        quot <= {quot[QUOT_W-2:0], ge};
        dsh  <= dsh >> 1;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

// File: hdl/servo_pan_sweep_controller.sv
// ----------------------------------------------------------------------------
// servo_pan_sweep_controller
// Per loop pass: key handling, manual stepping or metronome sweep, and the
// one-hot led bar position.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. A pass runs from acceptance
// to the next s_tready through these steps: take the key, the elapsed tick
// subtract, form the sweep dividend, the shared restoring divider (seven
// quotient steps plus completion) and the write of the result register. The
// divider serves both the sweep fraction 80*remaining/period and the manual
// led position (angle+70)/14. The result register lets the next pass start
// while a result still waits on m_tready; a pass only stalls in its last
// step if the previous result is untaken.
module servo_pan_sweep_controller (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // key_code [7:0], now_ms [39:8]
  input  logic [spsc_pkg::S_DATA_W-1:0] s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pan_angle [7:0], led_pattern [18:8], zero [23:19]
  output logic [spsc_pkg::M_DATA_W-1:0] m_tdata
);
  import spsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUB  = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;

  logic                      manual_mode;
  logic signed [ANGLE_W-1:0] angle;
  logic                      sweep_dir;
  logic [PERIOD_W-1:0]       sweep_period;
  logic [TICK_W-1:0]         period_start;
  logic [TICK_W-1:0]         tick;
  logic [TICK_W-1:0]         elapsed;
  logic                      tick_before;

  logic [ANGLE_W-1:0]        out_angle;
  logic [LED_W-1:0]          out_led;

  logic [KEY_W-1:0]          in_key;
  logic [NOW_W-1:0]          in_now;
  logic [TICK_W:0]           diff;
  logic                      flip;
  logic [PERIOD_W-1:0]       rem;
  logic [DIVIDEND_W-1:0]     met_dividend;
  logic [ANGLE_W-1:0]        man_sum;
  logic signed [ANGLE_W-1:0] mag;
  logic signed [ANGLE_W-1:0] met_angle;
  logic [ANGLE_W-1:0]        met_sum;
  logic [POS_W-1:0]          pos_raw;
  logic [POS_W-1:0]          pos;
  logic                      out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_key = s_tdata[KEY_W-1:0];
  assign in_now = s_tdata[KEY_W +: NOW_W];

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // borrow bit marks a tick before the period start
  assign diff = {1'b0, tick} - {1'b0, period_start};

  always_comb begin
    flip = !tick_before && (elapsed > TICK_W'(sweep_period));
    if (flip || tick_before) begin
      rem = sweep_period;
    end else begin
      rem = sweep_period - PERIOD_W'(elapsed);
    end
    // rem * 80 as two shifted terms
    met_dividend = (DIVIDEND_W'(rem) << 6) + (DIVIDEND_W'(rem) << 4);
    man_sum      = ANGLE_W'(angle + ANGLE_MAX);
  end

  always_comb begin
    div_req.start = (state == S_CALC);
    if (manual_mode) begin
      div_req.dividend = DIVIDEND_W'(man_sum);
      div_req.divisor  = LED_MAN_DIV;
    end else begin
      div_req.dividend = met_dividend;
      div_req.divisor  = sweep_period;
    end
  end

  spsc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    mag       = $signed({1'b0, div_rsp.quotient}) - SWEEP_HALF;
    met_angle = sweep_dir ? -mag : mag;
    met_sum   = ANGLE_W'(met_angle + SWEEP_HALF);
    if (manual_mode) begin
      pos_raw = div_rsp.quotient[POS_W-1:0];
    end else begin
      pos_raw = met_sum[LED_MET_SHIFT +: POS_W];
    end
    pos = (pos_raw > POS_LAST) ? POS_LAST : pos_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      manual_mode  <= 1'b0;
      angle        <= '0;
      sweep_dir    <= 1'b0;
      sweep_period <= PERIOD_MIN;
      period_start <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            tick  <= TICK_W'(in_now);
            state <= S_SUB;
            case (in_key)
              KEY_NEXT: begin
                if (manual_mode) begin
                  angle <= (angle < ANGLE_MIN + ANGLE_STEP) ? ANGLE_MIN
                                                            : angle - ANGLE_STEP;
                end else begin
                  manual_mode <= 1'b1;
                end
              end
              KEY_PREV: begin
                angle <= (angle > ANGLE_MAX - ANGLE_STEP) ? ANGLE_MAX
                                                          : angle + ANGLE_STEP;
              end
              KEY_METRO: begin
                manual_mode  <= 1'b0;
                period_start <= TICK_W'(in_now);
              end
              KEY_PLUS: begin
                sweep_period <= (sweep_period > PERIOD_MAX - PERIOD_STEP) ? PERIOD_MAX
                                : sweep_period + PERIOD_STEP;
              end
              KEY_MINUS: begin
                sweep_period <= (sweep_period < PERIOD_LOWER) ? PERIOD_MIN
                                : sweep_period - PERIOD_STEP;
              end
              default: begin
              end
            endcase
          end
        end
        S_SUB: begin
          elapsed     <= diff[TICK_W-1:0];
          tick_before <= diff[TICK_W];
          state       <= S_CALC;
        end
        S_CALC: begin
          if (!manual_mode && flip) begin
            sweep_dir    <= !sweep_dir;
            period_start <= tick;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            if (!manual_mode) begin
              angle     <= met_angle;
              out_angle <= met_angle;
            end else begin
              out_angle <= angle;
            end
            out_led <= LED_W'(1) << pos;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_led, out_angle};

  // divider runs only while a pass is in flight
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_rsp.busy)
    else $error("divider busy while accepting input");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider completion outside divide wait");

  a_led_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(out_led))
    else $error("led pattern not one-hot");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(out_angle) >= ANGLE_MIN && $signed(out_angle) <= ANGLE_MAX))
    else $error("pan angle out of range");

endmodule

// File: verif/servo_pan_sweep_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pan_sweep_controller_tb
// Streams loop passes (key code plus millisecond tick) into the controller
// and checks every angle and led bar result against an in-bench model of
// the manual stepping and the metronome sweep, under random stalls.
// ----------------------------------------------------------------------------
module servo_pan_sweep_controller_tb;
  import spsc_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 40;
  localparam int PHASE_PASSES = 310;
  localparam int PRINT_CAP    = 40;

  // no key received in this pass
  localparam logic [KEY_W-1:0] KEY_NONE = 8'h00;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [LED_W-1:0]          led;
  } pan_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  servo_pan_sweep_controller u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // model state of the controller
  bit     man_mode;
  int     man_angle;
  bit     sweep_neg;
  longint sweep_ms;
  longint start_ms;

  pan_result_t expected_pans[$];
  int          mismatch_count;
  int          passes_sent;
  int          results_seen;
  int          flip_count;
  int          early_tick_count;
  int          manual_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          cycle_count;
  logic [NOW_W-1:0] tick_now;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic pan_result_t predict_pass(logic [KEY_W-1:0] key, logic [NOW_W-1:0] now);
    longint      t;
    longint      rem;
    int          mag;
    int          pos;
    pan_result_t r;
    t = longint'(now);
    case (key)
      KEY_NEXT: begin
        if (man_mode) begin
          man_angle = man_angle - 10;
          if (man_angle < -70) man_angle = -70;
        end else begin
          man_mode = 1'b1;
        end
      end
      KEY_PREV: begin
        man_angle = man_angle + 10;
        if (man_angle > 70) man_angle = 70;
      end
      KEY_METRO: begin
        man_mode = 1'b0;
        start_ms = t;
      end
      KEY_PLUS: begin
        sweep_ms = sweep_ms + 1000;
        if (sweep_ms > 20000) sweep_ms = 20000;
      end
      KEY_MINUS: begin
        if (sweep_ms < 3000) sweep_ms = 2000;
        else sweep_ms = sweep_ms - 1000;
      end
      default: ;
    endcase
    if (man_mode) begin
      pos = (man_angle + 70) / 14;
      manual_count++;
    end else begin
      if (t > start_ms && t - start_ms > sweep_ms) begin
        sweep_neg = !sweep_neg;
        start_ms  = t;
        flip_count++;
      end
      if (t < start_ms) begin
        rem = sweep_ms;
        early_tick_count++;
      end else begin
        rem = sweep_ms - (t - start_ms);
      end
      mag = int'((80 * rem) / sweep_ms) - 40;
      man_angle = sweep_neg ? -mag : mag;
      pos = (man_angle + 40) / 8;
    end
    if (pos > 10) pos = 10;
    r.angle = man_angle[ANGLE_W-1:0];
    r.led   = LED_W'(1) << pos;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // entered and left at a falling edge; valid stays high when passes follow back to back
  task automatic send_pass(logic [KEY_W-1:0] key, logic [NOW_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, key};
    expected_pans.push_back(predict_pass(key, now));
    passes_sent++;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic rest_bus();
    s_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic pause_until_drained();
    rest_bus();
    while (expected_pans.size() != 0) @(negedge clk);
  endtask

  // check each result transaction against the oldest prediction
  always @(posedge clk) begin
    pan_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_pans.size() == 0) begin
        report_mismatch("unexpected result", int'(m_tdata), 0);
      end else begin
        want = expected_pans.pop_front();
        if ($signed(m_tdata[7:0]) != want.angle)
          report_mismatch("pan_angle", int'($signed(m_tdata[7:0])), int'(want.angle));
        if (m_tdata[18:8] != want.led)
          report_mismatch("led_pattern", int'(m_tdata[18:8]), int'(want.led));
        if (m_tdata[M_DATA_W-1:19] != '0)
          report_mismatch("pad bits", int'(m_tdata[M_DATA_W-1:19]), 0);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_pans.size());
      $display("servo_pan_sweep_controller test failed");
      $finish;
    end
  end

  // sweep edges: full remaining, zero remaining, period elapsed, tick before start
  task automatic test_sweep_directed();
    send_pass(KEY_NONE, 32'd0);
    send_pass(KEY_NONE, 32'd1000);
    send_pass(KEY_NONE, 32'd2000);
    send_pass(KEY_NONE, 32'd2001);
    send_pass(KEY_MINUS, 32'd2500);
    send_pass(KEY_PLUS, 32'd3000);
    send_pass(KEY_METRO, 32'd10000);
    send_pass(KEY_NONE, 32'd9000);
    send_pass(KEY_NONE, 32'hFFFF_FFFF);
    send_pass(KEY_METRO, 32'hFFFF_FFFF);
    send_pass(KEY_NONE, 32'd0);
    rest_bus();
  endtask

  // entering manual keeps the angle, stepping both ways, unknown codes, 'p' under sweep
  task automatic test_manual_directed();
    send_pass(KEY_NEXT, 32'd100);
    send_pass(KEY_NEXT, 32'd110);
    send_pass(KEY_NEXT, 32'd120);
    send_pass(KEY_NEXT, 32'd130);
    send_pass(KEY_PREV, 32'd140);
    send_pass(KEY_PREV, 32'd150);
    send_pass(8'hFF, 32'd160);
    send_pass(8'h6F, 32'd170);
    send_pass(KEY_METRO, 32'd300);
    send_pass(KEY_PREV, 32'd400);
    send_pass(KEY_NEXT, 32'd500);
    rest_bus();
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return KEY_NONE;
    if (sel < 44) return KEY_NEXT;
    if (sel < 58) return KEY_PREV;
    if (sel < 68) return KEY_METRO;
    if (sel < 79) return KEY_PLUS;
    if (sel < 90) return KEY_MINUS;
    return KEY_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [NOW_W-1:0] next_tick(logic [NOW_W-1:0] now);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return now + NOW_W'($urandom_range(0, 3000));
    if (sel < 88) return now + NOW_W'($urandom_range(3000, 25000));
    if (sel < 96) return now - NOW_W'($urandom_range(1, 5000));
    if (sel < 98) return NOW_W'($urandom());
    return 32'hFFFF_FFFF - NOW_W'($urandom_range(0, 30000));
  endfunction

  // runs of one key with a moving tick, so saturation of angle and period is reached
  task automatic test_random_phase(int idle_in, int idle_out, int count);
    logic [KEY_W-1:0] key;
    int               run;
    int               sent;
    send_idle_pct = idle_in;
    recv_idle_pct = idle_out;
    sent = 0;
    while (sent < count) begin
      key = pick_key();
      run = ($urandom_range(0, 9) < 2) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      repeat (run) begin
        tick_now = next_tick(tick_now);
        send_pass(key, tick_now);
        sent++;
        if (sent % 100 == 50) pause_until_drained();
      end
    end
    rest_bus();
  endtask

  initial begin
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    man_mode       = 1'b0;
    man_angle      = 0;
    sweep_neg      = 1'b0;
    sweep_ms       = 2000;
    start_ms       = 0;
    mismatch_count = 0;
    passes_sent    = 0;
    results_seen   = 0;
    flip_count     = 0;
    early_tick_count = 0;
    manual_count   = 0;
    cycle_count    = 0;
    send_idle_pct  = 36;
    recv_idle_pct  = 67;
    tick_now       = 32'd600;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_sweep_directed();
    test_manual_directed();
    test_random_phase(36, 67, PHASE_PASSES);
    test_random_phase(67, 36, PHASE_PASSES);
    test_random_phase(0, 0, PHASE_PASSES);

    pause_until_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_pans.size() != 0)
      report_mismatch("results missing", 0, expected_pans.size());

    $display("covered %0d passes, %0d results checked, %0d in manual mode", passes_sent,
             results_seen, manual_count);
    $display("sweep flips %0d, ticks before period start %0d", flip_count, early_tick_count);
    if (mismatch_count == 0) begin
      $display("servo_pan_sweep_controller test passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("servo_pan_sweep_controller test failed");
    end
    $finish;
  end

endmodule
